// File: hw/rtl/pph_pkg.sv
// ----------------------------------------------------------------------------
// pph_pkg
// Shared types, constants and helpers for the pixel pair distance histogram.
// ----------------------------------------------------------------------------
package pph_pkg;

  // Counter and histogram geometry
  localparam int unsigned COUNT_WIDTH = 32;
  localparam int unsigned NUM_BINS    = 2000;
  localparam int unsigned BIN_W       = $clog2(NUM_BINS);
  localparam int unsigned OUT_COUNT_W = 32;

  // Input field widths
  localparam int unsigned X_W    = 10;
  localparam int unsigned Y_W    = 11;
  localparam int unsigned CFG_W  = 11;
  localparam int unsigned CIDX_W = 2;

  // Bin index strides
  localparam int unsigned DX_STRIDE = 100;
  localparam int unsigned DY_STRIDE = 10;

  // Window limits, expressed before the divisions by 2 and by 5
  localparam int unsigned DX_SUM_MIN = 2;   // dx = 1
  localparam int unsigned DX_SUM_MAX = 39;  // dx = 19
  localparam int unsigned DV5_MIN    = 5;   // quotient 1
  localparam int unsigned DV5_MAX    = 49;  // quotient 9

  // Operation codes
  localparam logic OP_ACCUM = 1'b0;
  localparam logic OP_READ  = 1'b1;

  // Register indexes
  localparam logic [CIDX_W-1:0] REG_LEFT_WIDTH    = 2'd0;
  localparam logic [CIDX_W-1:0] REG_SPACING       = 2'd1;
  localparam logic [CIDX_W-1:0] REG_LEFT_XHEIGHT  = 2'd2;
  localparam logic [CIDX_W-1:0] REG_RIGHT_XHEIGHT = 2'd3;

  // Configuration register set
  typedef struct packed {
    logic [X_W-1:0]          left_width;
    logic signed [CFG_W-1:0] letter_spacing;
    logic [X_W-1:0]          left_xheight;
    logic [X_W-1:0]          right_xheight;
  } cfg_t;

  // Bin lookup result
  typedef struct packed {
    logic             hit;
    logic [BIN_W-1:0] bin;
  } bin_res_t;

  // Histogram memory request
  typedef struct packed {
    logic                   re;
    logic [BIN_W-1:0]       raddr;
    logic                   we;
    logic [BIN_W-1:0]       waddr;
    logic [COUNT_WIDTH-1:0] wdata;
  } mem_req_t;

  // Sequencer states
  typedef enum logic [3:0] {
    ST_CLEAR  = 4'b0001,
    ST_IDLE   = 4'b0010,
    ST_LOOKUP = 4'b0100,
    ST_UPDATE = 4'b1000
  } state_e;

  // v / 5 for v < 64 by reciprocal multiply (13/64)
  function automatic logic [3:0] div5(input logic [5:0] v);
    logic [11:0] p;
    p = 12'(v) * 12'(13);
    return p[9:6];
  endfunction

  // Counter value to the 32-bit result field (zero extend or truncate)
  function automatic logic [OUT_COUNT_W-1:0] to_out_count(
      input logic [COUNT_WIDTH-1:0] v);
    logic [COUNT_WIDTH+OUT_COUNT_W-1:0] e;
    e = (COUNT_WIDTH + OUT_COUNT_W)'(v);
    return e[OUT_COUNT_W-1:0];
  endfunction

endpackage

// File: hw/rtl/pph_bin_calc.sv
// ----------------------------------------------------------------------------
// pph_bin_calc
// Maps one pixel pair to its histogram bin and flags whether it counts.
// ----------------------------------------------------------------------------
module pph_bin_calc (
  input  pph_pkg::cfg_t                  cfg_i,
  input  logic [pph_pkg::X_W-1:0]        left_x_i,
  input  logic signed [pph_pkg::Y_W-1:0] left_y_i,
  input  logic [pph_pkg::X_W-1:0]        right_x_i,
  input  logic signed [pph_pkg::Y_W-1:0] right_y_i,
  output pph_pkg::bin_res_t              res_o
);

  logic              y_ok;
  logic signed [12:0] dx_sum;
  logic              dx_ok;
  logic [10:0]       y_diff;
  logic [9:0]        dy_abs;
  logic              dy_ok;
  logic [10:0]       y_sum;
  logic [9:0]        y_half;
  logic              ya_ok;
  logic [4:0]        dx;
  logic [3:0]        dy;
  logic [3:0]        ya;

  // Both y must be non-negative and within their glyph's x-height
  assign y_ok = !left_y_i[pph_pkg::Y_W-1] && !right_y_i[pph_pkg::Y_W-1] &&
                (left_y_i[pph_pkg::X_W-1:0]  <= cfg_i.left_xheight) &&
                (right_y_i[pph_pkg::X_W-1:0] <= cfg_i.right_xheight);

  // Horizontal distance; negative sums never land in the window
  assign dx_sum = $signed({3'b000, right_x_i}) - $signed({3'b000, left_x_i}) +
                  $signed({3'b000, cfg_i.left_width}) +
                  $signed({{2{cfg_i.letter_spacing[pph_pkg::CFG_W-1]}},
                           cfg_i.letter_spacing});
  assign dx_ok  = !dx_sum[12] &&
                  (dx_sum[11:0] >= 12'(pph_pkg::DX_SUM_MIN)) &&
                  (dx_sum[11:0] <= 12'(pph_pkg::DX_SUM_MAX));
  assign dx     = dx_sum[5:1];

  // Vertical distance magnitude
  assign y_diff = {1'b0, right_y_i[pph_pkg::X_W-1:0]} -
                  {1'b0, left_y_i[pph_pkg::X_W-1:0]};
  assign dy_abs = y_diff[10] ? 10'(-y_diff) : y_diff[9:0];
  assign dy_ok  = (dy_abs >= 10'(pph_pkg::DV5_MIN)) &&
                  (dy_abs <= 10'(pph_pkg::DV5_MAX));
  assign dy     = pph_pkg::div5(dy_abs[5:0]);

  // Mean height, floored (both y are non-negative here)
  assign y_sum  = {1'b0, right_y_i[pph_pkg::X_W-1:0]} +
                  {1'b0, left_y_i[pph_pkg::X_W-1:0]};
  assign y_half = y_sum[10:1];
  assign ya_ok  = (y_half >= 10'(pph_pkg::DV5_MIN)) &&
                  (y_half <= 10'(pph_pkg::DV5_MAX));
  assign ya     = pph_pkg::div5(y_half[5:0]);

  // Bin index
  always_comb begin
    res_o.hit = y_ok && dx_ok && dy_ok && ya_ok;
    res_o.bin = pph_pkg::BIN_W'(dx) * pph_pkg::BIN_W'(pph_pkg::DX_STRIDE) +
                pph_pkg::BIN_W'(dy) * pph_pkg::BIN_W'(pph_pkg::DY_STRIDE) +
                pph_pkg::BIN_W'(ya);
  end

endmodule

// File: hw/rtl/pph_hist_mem.sv
// ----------------------------------------------------------------------------
// pph_hist_mem
// Histogram counter store: one write and one registered read per cycle.
// ----------------------------------------------------------------------------
module pph_hist_mem (
  input  logic                            clk_i,
  input  pph_pkg::mem_req_t               req_i,
  output logic [pph_pkg::COUNT_WIDTH-1:0] rdata_o
);

  logic [pph_pkg::COUNT_WIDTH-1:0] mem_q [pph_pkg::NUM_BINS];

  // Write port
  always_ff @(posedge clk_i) begin
    if (req_i.we) begin
      mem_q[req_i.waddr] <= req_i.wdata;
    end
  end

  // Read port, registered
  always_ff @(posedge clk_i) begin
    if (req_i.re) begin
      rdata_o <= mem_q[req_i.raddr];
    end
  end

endmodule

// File: hw/rtl/pixel_pair_distance_histogram.sv
// ----------------------------------------------------------------------------
// pixel_pair_distance_histogram
// Accumulates a 2000-bin distance histogram over pixel pairs, with
// read-and-clear access to single bins.
// ----------------------------------------------------------------------------
// After reset the block sweeps all 2000 bins to zero, one per cycle, and
// holds in_ready_o low until the sweep is done; configuration writes are
// taken throughout. Each item then goes through accept, bin lookup with
// the memory read, and the write-back that loads the result register.
// The memory read is registered, so the write-back of the same bin is a
// step of its own. The result sits in an output register, so the next
// item is accepted while a result still waits to be taken; the update
// stage stalls only when that register is still full.
// ----------------------------------------------------------------------------
module pixel_pair_distance_histogram (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  // Configuration
  input  logic                                cfg_we_i,
  input  logic [pph_pkg::CIDX_W-1:0]          cfg_addr_i,
  input  logic [pph_pkg::CFG_W-1:0]           cfg_wdata_i,
  // Input items
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  logic                                operation_i,
  input  logic [pph_pkg::X_W-1:0]             left_x_i,
  input  logic signed [pph_pkg::Y_W-1:0]      left_y_i,
  input  logic [pph_pkg::X_W-1:0]             right_x_i,
  input  logic signed [pph_pkg::Y_W-1:0]      right_y_i,
  input  logic [pph_pkg::BIN_W-1:0]           read_bin_i,
  // Result items
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output logic                                hit_o,
  output logic [pph_pkg::BIN_W-1:0]           bin_o,
  output logic [pph_pkg::OUT_COUNT_W-1:0]     count_o
);

  pph_pkg::state_e   state_q, state_d;
  pph_pkg::cfg_t     cfg_q;
  pph_pkg::bin_res_t calc_res;
  pph_pkg::mem_req_t mem_req;

  logic [pph_pkg::BIN_W-1:0]       clr_q;
  logic [pph_pkg::COUNT_WIDTH-1:0] rdata;

  // Captured item fields
  logic                            op_q;
  logic [pph_pkg::X_W-1:0]         lx_q;
  logic signed [pph_pkg::Y_W-1:0]  ly_q;
  logic [pph_pkg::X_W-1:0]         rx_q;
  logic signed [pph_pkg::Y_W-1:0]  ry_q;
  logic [pph_pkg::BIN_W-1:0]       rb_q;

  // Lookup results
  logic                            hit_q;
  logic [pph_pkg::BIN_W-1:0]       addr_q;
  logic                            rb_ok;
  logic                            rb_ok_q;

  // Output register
  logic                            out_valid_q;
  logic                            out_free;
  logic                            do_update;
  logic [pph_pkg::COUNT_WIDTH-1:0] count_inc;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.left_width     <= '0;
      cfg_q.letter_spacing <= '0;
      cfg_q.left_xheight   <= '1;
      cfg_q.right_xheight  <= '1;
    end else if (cfg_we_i) begin
      unique case (cfg_addr_i)
        pph_pkg::REG_LEFT_WIDTH:    cfg_q.left_width     <= cfg_wdata_i[pph_pkg::X_W-1:0];
        pph_pkg::REG_SPACING:       cfg_q.letter_spacing <= $signed(cfg_wdata_i);
        pph_pkg::REG_LEFT_XHEIGHT:  cfg_q.left_xheight   <= cfg_wdata_i[pph_pkg::X_W-1:0];
        pph_pkg::REG_RIGHT_XHEIGHT: cfg_q.right_xheight  <= cfg_wdata_i[pph_pkg::X_W-1:0];
        default: ;
      endcase
    end
  end

  // Handshake helpers
  assign in_ready_o = (state_q == pph_pkg::ST_IDLE);
  assign out_free   = !out_valid_q || out_ready_i;
  assign do_update  = (state_q == pph_pkg::ST_UPDATE) && out_free;
  assign rb_ok      = (rb_q < pph_pkg::BIN_W'(pph_pkg::NUM_BINS));

  // Bin mapping from the captured pair
  pph_bin_calc u_bin_calc (
    .cfg_i     (cfg_q),
    .left_x_i  (lx_q),
    .left_y_i  (ly_q),
    .right_x_i (rx_q),
    .right_y_i (ry_q),
    .res_o     (calc_res)
  );

  // Sequencer
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      pph_pkg::ST_CLEAR: begin
        if (clr_q == pph_pkg::BIN_W'(pph_pkg::NUM_BINS - 1)) begin
          state_d = pph_pkg::ST_IDLE;
        end
      end
      pph_pkg::ST_IDLE: begin
        if (in_valid_i) begin
          state_d = pph_pkg::ST_LOOKUP;
        end
      end
      pph_pkg::ST_LOOKUP: state_d = pph_pkg::ST_UPDATE;
      pph_pkg::ST_UPDATE: begin
        if (out_free) begin
          state_d = pph_pkg::ST_IDLE;
        end
      end
      default: state_d = pph_pkg::ST_CLEAR;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= pph_pkg::ST_CLEAR;
      clr_q   <= '0;
    end else begin
      state_q <= state_d;
      if (state_q == pph_pkg::ST_CLEAR) begin
        clr_q <= clr_q + 1'b1;
      end
    end
  end

  // Capture the accepted item
  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      op_q <= operation_i;
      lx_q <= left_x_i;
      ly_q <= left_y_i;
      rx_q <= right_x_i;
      ry_q <= right_y_i;
      rb_q <= read_bin_i;
    end
  end

  // Hold the lookup outcome for the write-back
  always_ff @(posedge clk_i) begin
    if (state_q == pph_pkg::ST_LOOKUP) begin
      hit_q   <= (op_q == pph_pkg::OP_ACCUM) && calc_res.hit;
      addr_q  <= (op_q == pph_pkg::OP_READ) ? (rb_ok ? rb_q : '0) : calc_res.bin;
      rb_ok_q <= rb_ok;
    end
  end

  // Saturating increment of the fetched counter
  assign count_inc = (&rdata) ? rdata : rdata + 1'b1;

  // Memory requests: clearing sweep, lookup read, write-back
  always_comb begin
    mem_req.re    = (state_q == pph_pkg::ST_LOOKUP);
    mem_req.raddr = (op_q == pph_pkg::OP_READ) ? (rb_ok ? rb_q : '0) : calc_res.bin;
    mem_req.we    = 1'b0;
    mem_req.waddr = addr_q;
    mem_req.wdata = '0;
    if (state_q == pph_pkg::ST_CLEAR) begin
      mem_req.we    = 1'b1;
      mem_req.waddr = clr_q;
    end else if (do_update) begin
      if (op_q == pph_pkg::OP_READ) begin
        mem_req.we = rb_ok_q;
      end else begin
        mem_req.we    = hit_q;
        mem_req.wdata = count_inc;
      end
    end
  end

  pph_hist_mem u_hist_mem (
    .clk_i   (clk_i),
    .req_i   (mem_req),
    .rdata_o (rdata)
  );

  // Result register valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (do_update) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  // Result payload
  always_ff @(posedge clk_i) begin
    if (do_update) begin
      if (op_q == pph_pkg::OP_READ) begin
        hit_o   <= 1'b0;
        bin_o   <= rb_q;
        count_o <= rb_ok_q ? pph_pkg::to_out_count(rdata) : '0;
      end else begin
        hit_o   <= hit_q;
        bin_o   <= hit_q ? addr_q : '0;
        count_o <= hit_q ? pph_pkg::to_out_count(count_inc) : '0;
      end
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

// File: bench/pph_bin_checker.sv
// ----------------------------------------------------------------------------
// pph_bin_checker
// Watches the register port and both item channels of the pixel pair
// distance histogram. It keeps its own copy of the registers and bin
// counters, works out the result for every accepted item, and compares each
// result item with the oldest tally still owed.
// ----------------------------------------------------------------------------
module pph_bin_checker
  import pph_pkg::*;
(
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // Register port
  input  logic                          cfg_we_i,
  input  logic [CIDX_W-1:0]             cfg_addr_i,
  input  logic [CFG_W-1:0]              cfg_wdata_i,
  // Input items
  input  logic                          in_valid_i,
  input  logic                          in_ready_i,
  input  logic                          operation_i,
  input  logic [X_W-1:0]                left_x_i,
  input  logic signed [Y_W-1:0]         left_y_i,
  input  logic [X_W-1:0]                right_x_i,
  input  logic signed [Y_W-1:0]         right_y_i,
  input  logic [BIN_W-1:0]              read_bin_i,
  // Result items
  input  logic                          out_valid_i,
  input  logic                          out_ready_i,
  input  logic                          hit_i,
  input  logic [BIN_W-1:0]              bin_i,
  input  logic [OUT_COUNT_W-1:0]        count_i,
  // Status toward the stimulus side
  output int unsigned                   fail_count_o,
  output int unsigned                   pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  // One predicted result item
  typedef struct packed {
    logic                   hit;
    logic [BIN_W-1:0]       bin;
    logic [OUT_COUNT_W-1:0] count;
  } tally_t;

  // Open windows for dx, and for dy / yavg
  localparam int DX_LIMIT = 20;
  localparam int DV_LIMIT = 10;

  cfg_t                   cfg_q;
  logic [COUNT_WIDTH-1:0] bin_counts [NUM_BINS];
  tally_t                 tally_queue [$];
  int unsigned            fails;

  // Bin that a pixel pair lands in; hit low when skipped or out of window
  function automatic bin_res_t locate_bin(
      input logic [X_W-1:0]        lx,
      input logic signed [Y_W-1:0] ly,
      input logic [X_W-1:0]        rx,
      input logic signed [Y_W-1:0] ry,
      input cfg_t                  c);
    int       ly_v;
    int       ry_v;
    int       spacing;
    int       dx;
    int       span;
    int       dy;
    int       yavg;
    bin_res_t res;
    res     = '0;
    ly_v    = ly;
    ry_v    = ry;
    spacing = c.letter_spacing;
    // negative y or above the glyph's x-height: pair skipped
    if (ly_v < 0 || ry_v < 0 ||
        ly_v > int'(c.left_xheight) || ry_v > int'(c.right_xheight)) begin
      return res;
    end
    // divisions truncate toward zero
    dx   = (int'(rx) - int'(lx) + int'(c.left_width) + spacing) / 2;
    span = ry_v - ly_v;
    if (span < 0) begin
      span = -span;
    end
    dy   = span / 5;
    yavg = ((ry_v + ly_v) / 2) / 5;
    if (dx > 0 && dx < DX_LIMIT && dy > 0 && dy < DV_LIMIT &&
        yavg > 0 && yavg < DV_LIMIT) begin
      res.hit = 1'b1;
      res.bin = BIN_W'(int'(DX_STRIDE) * dx + int'(DY_STRIDE) * dy + yavg);
    end
    return res;
  endfunction

  // Register mirror, result compare, then prediction for the new item
  always @(posedge clk_i or negedge rst_ni) begin
    tally_t   want;
    bin_res_t loc;
    if (!rst_ni) begin
      cfg_q = '{left_width: '0, letter_spacing: '0, left_xheight: '1,
                right_xheight: '1};
      foreach (bin_counts[i]) bin_counts[i] = '0;
      tally_queue.delete();
      fails = 0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_addr_i)
          REG_LEFT_WIDTH:    cfg_q.left_width     = cfg_wdata_i[X_W-1:0];
          REG_SPACING:       cfg_q.letter_spacing = cfg_wdata_i;
          REG_LEFT_XHEIGHT:  cfg_q.left_xheight   = cfg_wdata_i[X_W-1:0];
          REG_RIGHT_XHEIGHT: cfg_q.right_xheight  = cfg_wdata_i[X_W-1:0];
          default: ;
        endcase
      end

      // results leave in item order, so compare with the oldest tally
      if (out_valid_i && out_ready_i) begin
        if (tally_queue.size() == 0) begin
          $error("result with nothing owed: hit %0d bin %0d count %0d",
                 hit_i, bin_i, count_i);
          fails++;
        end else begin
          want = tally_queue.pop_front();
          if (hit_i !== want.hit) begin
            $error("hit: expected %0d, got %0d", want.hit, hit_i);
            fails++;
          end
          if (bin_i !== want.bin) begin
            $error("bin: expected %0d, got %0d", want.bin, bin_i);
            fails++;
          end
          if (count_i !== want.count) begin
            $error("count: expected %0d, got %0d", want.count, count_i);
            fails++;
          end
        end
      end

      if (in_valid_i && in_ready_i) begin
        want = '0;
        if (operation_i == OP_READ) begin
          // read and clear; an index past the last bin only echoes back
          want.bin = read_bin_i;
          if (int'(read_bin_i) < int'(NUM_BINS)) begin
            want.count             = OUT_COUNT_W'(bin_counts[read_bin_i]);
            bin_counts[read_bin_i] = '0;
          end
        end else begin
          loc = locate_bin(left_x_i, left_y_i, right_x_i, right_y_i, cfg_q);
          if (loc.hit) begin
            // counters hold at all ones
            if (bin_counts[loc.bin] != '1) begin
              bin_counts[loc.bin] = bin_counts[loc.bin] + COUNT_WIDTH'(1);
            end
            want.hit   = 1'b1;
            want.bin   = loc.bin;
            want.count = OUT_COUNT_W'(bin_counts[loc.bin]);
          end
        end
        tally_queue.push_back(want);
      end
    end
    fail_count_o <= fails;
    pending_o    <= tally_queue.size();
  end

endmodule

// File: bench/pixel_pair_distance_histogram_tb.sv
// ----------------------------------------------------------------------------
// pixel_pair_distance_histogram_tb
// Drives pixel pairs and bin reads into the histogram block under several
// register settings, with bursty input and a stalling result receiver.
// A checker beside the block predicts and compares every result item.
// ----------------------------------------------------------------------------
module pixel_pair_distance_histogram_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import pph_pkg::*;

  localparam int IDLE_LIMIT  = 20000;
  localparam int DRAIN_TAIL  = 16;
  localparam int NUM_PHASES  = 6;
  localparam int PHASE_ITEMS = 100;

  // Receiver behavior, picked anew whenever its random countdown runs out
  typedef enum int {
    RX_STREAM,
    RX_COIN,
    RX_SPARSE,
    RX_BLOCKY
  } rx_mode_e;

  logic                   clk_i;
  logic                   rst_ni;
  logic                   cfg_we_i;
  logic [CIDX_W-1:0]      cfg_addr_i;
  logic [CFG_W-1:0]       cfg_wdata_i;
  logic                   in_valid_i;
  logic                   in_ready_o;
  logic                   operation_i;
  logic [X_W-1:0]         left_x_i;
  logic signed [Y_W-1:0]  left_y_i;
  logic [X_W-1:0]         right_x_i;
  logic signed [Y_W-1:0]  right_y_i;
  logic [BIN_W-1:0]       read_bin_i;
  logic                   out_valid_o;
  logic                   out_ready_i = 1'b0;
  logic                   hit_o;
  logic [BIN_W-1:0]       bin_o;
  logic [OUT_COUNT_W-1:0] count_o;

  int unsigned fail_count;
  int unsigned pending;

  // Register values last written, used to aim pairs at the bin window
  int lw_now;
  int sp_now;
  int lxh_now;
  int rxh_now;

  // Bin that about half of the well-formed pairs of a phase aim at
  int focus_dx;
  int focus_dy;
  int focus_ya;

  int       burst_left;
  int       quiet_cycles;
  rx_mode_e stall_mode;
  int       stall_left;

  pixel_pair_distance_histogram u_dut (.*);

  pph_bin_checker u_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_addr_i   (cfg_addr_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .in_valid_i   (in_valid_i),
    .in_ready_i   (in_ready_o),
    .operation_i  (operation_i),
    .left_x_i     (left_x_i),
    .left_y_i     (left_y_i),
    .right_x_i    (right_x_i),
    .right_y_i    (right_y_i),
    .read_bin_i   (read_bin_i),
    .out_valid_i  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .hit_i        (hit_o),
    .bin_i        (bin_o),
    .count_i      (count_o),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  // Clock
  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  // Result receiver stalls
  always @(posedge clk_i) begin
    if (stall_left == 0) begin
      stall_mode = rx_mode_e'($urandom_range(0, 3));
      stall_left = $urandom_range(16, 96);
    end else begin
      stall_left--;
    end
    case (stall_mode)
      RX_STREAM: out_ready_i <= 1'b1;
      RX_COIN:   out_ready_i <= 1'($urandom_range(0, 1));
      RX_SPARSE: out_ready_i <= ($urandom_range(0, 5) == 0);
      default:   out_ready_i <= ((stall_left % 16) < 11);
    endcase
  end

  // Watchdog: too long without any item moving
  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= IDLE_LIMIT) begin
      $display("pixel_pair_distance_histogram regression: fail");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Present one item and hold it until accepted
  task automatic offer(input logic op, input logic [X_W-1:0] lx,
                       input logic [Y_W-1:0] ly, input logic [X_W-1:0] rx,
                       input logic [Y_W-1:0] ry, input logic [BIN_W-1:0] rb);
    in_valid_i  <= 1'b1;
    operation_i <= op;
    left_x_i    <= lx;
    left_y_i    <= ly;
    right_x_i   <= rx;
    right_y_i   <= ry;
    read_bin_i  <= rb;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
  endtask

  // Sender bursts: random length, random gap before each burst
  task automatic pace();
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap != 0) begin
        in_valid_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
    burst_left--;
  endtask

  task automatic send_pair(input int lx, input int ly, input int rx, input int ry);
    pace();
    offer(OP_ACCUM, X_W'(lx), Y_W'(ly), X_W'(rx), Y_W'(ry), BIN_W'($urandom));
  endtask

  task automatic send_read(input int rb);
    pace();
    offer(OP_READ, X_W'($urandom), Y_W'($urandom), X_W'($urandom), Y_W'($urandom),
          BIN_W'(rb));
  endtask

  // Stop sending and wait for every owed result, then a short tail
  task automatic drain();
    in_valid_i <= 1'b0;
    burst_left = 0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (DRAIN_TAIL) @(posedge clk_i);
  endtask

  // Write all four registers on back-to-back cycles
  task automatic load_config(input int lw, input int sp, input int lxh, input int rxh);
    lw_now      = lw;
    sp_now      = sp;
    lxh_now     = lxh;
    rxh_now     = rxh;
    cfg_we_i    <= 1'b1;
    cfg_addr_i  <= REG_LEFT_WIDTH;
    cfg_wdata_i <= CFG_W'(lw);
    @(posedge clk_i);
    cfg_addr_i  <= REG_SPACING;
    cfg_wdata_i <= CFG_W'(sp);
    @(posedge clk_i);
    cfg_addr_i  <= REG_LEFT_XHEIGHT;
    cfg_wdata_i <= CFG_W'(lxh);
    @(posedge clk_i);
    cfg_addr_i  <= REG_RIGHT_XHEIGHT;
    cfg_wdata_i <= CFG_W'(rxh);
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
  endtask

  // Mostly pairs built to land on a chosen (dx, dy, yavg), plus reads and noise
  task automatic random_item();
    int kind;
    int pick;
    int nudge;
    int dx;
    int dy;
    int ya;
    int delta;
    int span;
    int total;
    int lo;
    int hi;
    int lx;
    int rx;
    int ly;
    int ry;
    kind = $urandom_range(0, 99);
    if (kind < 12) begin
      // noise: every field random, operation too
      pace();
      offer(1'($urandom), X_W'($urandom), Y_W'($urandom), X_W'($urandom),
            Y_W'($urandom), BIN_W'($urandom));
    end else if (kind < 28) begin
      pick = $urandom_range(0, 4);
      if (pick < 2) begin
        send_read(int'(DX_STRIDE) * focus_dx + int'(DY_STRIDE) * focus_dy + focus_ya);
      end else if (pick < 4) begin
        send_read(int'(DX_STRIDE) * int'($urandom_range(0, 20)) +
                  int'(DY_STRIDE) * int'($urandom_range(0, 10)) +
                  int'($urandom_range(0, 9)));
      end else begin
        send_read($urandom_range(0, 2047));
      end
    end else begin
      if (kind < 64) begin
        dx = focus_dx;
        dy = focus_dy;
        ya = focus_ya;
      end else begin
        dx = $urandom_range(0, 20);
        dy = $urandom_range(0, 10);
        ya = $urandom_range(0, 10);
      end
      // horizontal: a sum that halves to dx, less the register offset
      if (dx == 0) begin
        delta = int'($urandom_range(0, 2)) - 1;
      end else begin
        delta = 2 * dx + int'($urandom_range(0, 1));
      end
      delta = delta - lw_now - sp_now;
      if (delta > 1023 || delta < -1023) begin
        lx = $urandom_range(0, 1023);
        rx = $urandom_range(0, 1023);
      end else if (delta >= 0) begin
        lx = $urandom_range(0, 1023 - delta);
        rx = lx + delta;
      end else begin
        rx = $urandom_range(0, 1023 + delta);
        lx = rx - delta;
      end
      // vertical: distance and doubled mean need the same parity
      span  = 5 * dy + int'($urandom_range(0, 4));
      total = 10 * ya + int'($urandom_range(0, 9));
      if ((total + span) % 2 != 0) begin
        total = (total % 10 == 9) ? total - 1 : total + 1;
      end
      hi = (total + span) / 2;
      lo = (total - span) / 2;
      if ($urandom_range(0, 1) == 1) begin
        ly = lo;
        ry = hi;
      end else begin
        ly = hi;
        ry = lo;
      end
      // now and then sit on or just past an x-height
      nudge = $urandom_range(0, 9);
      if (nudge == 0) begin
        ly = lxh_now + int'($urandom_range(0, 1));
      end else if (nudge == 1) begin
        ry = rxh_now + int'($urandom_range(0, 1));
      end
      send_pair(lx, ly, rx, ry);
    end
  endtask

  // Stimulus and verdict
  initial begin
    rst_ni      = 1'b0;
    cfg_we_i    = 1'b0;
    cfg_addr_i  = REG_LEFT_WIDTH;
    cfg_wdata_i = '0;
    in_valid_i  = 1'b0;
    operation_i = OP_ACCUM;
    left_x_i    = '0;
    left_y_i    = '0;
    right_x_i   = '0;
    right_y_i   = '0;
    read_bin_i  = '0;
    lw_now      = 0;
    sp_now      = 0;
    lxh_now     = 1023;
    rxh_now     = 1023;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Register reset values: window edges, skips, reads
    send_pair(0, 10, 10, 30);        // hit, count 1
    send_pair(0, 10, 10, 30);        // same bin, count 2
    send_read(544);                  // returns 2 and clears
    send_read(544);                  // now 0
    send_pair(0, -1, 10, 30);        // negative left y
    send_pair(0, 10, 10, -1024);     // most negative right y
    send_pair(1023, 1023, 0, 1023);  // dx negative, dy zero
    send_pair(0, 1023, 1023, 0);     // dx far above window
    send_pair(100, 10, 102, 30);     // dx at its low edge
    send_pair(100, 10, 101, 30);     // dx rounds to zero
    send_pair(0, 10, 39, 30);        // dx at its high edge
    send_pair(0, 10, 40, 30);        // dx one past
    send_pair(0, 3, 10, 8);          // dy and yavg at low edge
    send_pair(0, 10, 10, 14);        // dy zero
    send_pair(0, 25, 10, 74);        // dy and yavg at high edge
    send_pair(0, 20, 10, 70);        // dy one past
    send_pair(0, 2, 10, 7);          // yavg zero
    send_pair(0, 40, 10, 60);        // yavg one past
    send_read(2047);                 // largest index, out of range
    send_read(2000);                 // first index past the end
    send_read(1999);
    send_read(0);
    drain();

    // Small x-heights and a negative spacing
    load_config(512, -500, 60, 45);
    send_pair(0, 60, 0, 30);         // left y on its x-height
    send_pair(0, 61, 0, 30);         // left y just above
    send_pair(0, 40, 0, 45);         // right y on its x-height
    send_pair(0, 40, 0, 46);         // right y just above
    send_pair(13, 40, 0, 45);        // horizontal sum of -1 truncates to 0

    // Random phases over several register settings
    for (int p = 0; p < NUM_PHASES; p++) begin
      drain();
      case (p)
        0:       load_config(0, 0, 1023, 1023);
        1:       load_config(1023, -1024, 0, 1023);
        2:       load_config(0, 1023, 1023, 0);
        3:       load_config(512, -500, 60, 45);
        default: load_config($urandom_range(0, 1023), int'($urandom_range(0, 2047)) - 1024,
                             $urandom_range(20, 1023), $urandom_range(20, 1023));
      endcase
      focus_dx = $urandom_range(1, 19);
      focus_dy = $urandom_range(1, 9);
      focus_ya = $urandom_range(1, 9);
      repeat (PHASE_ITEMS) random_item();
    end
    drain();

    if (fail_count == 0) begin
      $display("pixel_pair_distance_histogram regression: pass");
    end else begin
      $display("pixel_pair_distance_histogram regression: fail");
    end
    $finish;
  end

endmodule
